FILE: design/ioapic_register_file_defines.svh
// Assertion helpers for the register file controller.
`ifndef IOAPIC_REGISTER_FILE_DEFINES_SVH
`define IOAPIC_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("register file check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("register file sequencing check failed");

`endif

FILE: design/irf_pkg.sv
`timescale 1ns / 1ps

package irf_pkg;

	localparam int DEF_ENTRIES = 24;

	localparam logic [7:0] OFF_SELECT = 8'h00;
	localparam logic [7:0] OFF_WINDOW = 8'h10;

	localparam logic [7:0] SEL_ID    = 8'h00;
	localparam logic [7:0] SEL_VER   = 8'h01;
	localparam logic [7:0] SEL_ARB   = 8'h02;
	localparam logic [7:0] SEL_TABLE = 8'h10;

	localparam logic [7:0] VER_CODE = 8'h20;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FORM
	} state_t;

	// How the output register is built from the execute-stage results.
	typedef enum logic [1:0] {
		RES_DIRECT,
		RES_TBL_LO,
		RES_TBL_HI,
		RES_QUERY
	} res_kind_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} ctl_cmd_t;

endpackage

FILE: design/irf_ctrl.sv
`timescale 1ns / 1ps
`include "ioapic_register_file_defines.svh"

module irf_ctrl
	import irf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	output logic     m_axis_tvalid,
	input  logic     m_axis_tready,
	output ctl_cmd_t ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl.capture  = 1'b0;
		ctl.exec     = 1'b0;
		ctl.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					ctl.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_FORM;
			end
			ST_FORM: begin
				// A finished result may only replace one that is leaving.
				if (!out_valid_q || m_axis_tready) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	`IRF_ASSERT_NEXT(a_accept_then_exec, clk, arst_n, s_axis_tvalid && s_axis_tready, ctl.exec)
	`IRF_ASSERT_NEXT(a_exec_then_form, clk, arst_n, ctl.exec, state_q == ST_FORM)
	`IRF_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, ctl.load_out, !out_valid_q || m_axis_tready)
	`IRF_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, ctl.load_out, m_axis_tvalid)

endmodule

FILE: design/irf_datapath.sv
`timescale 1ns / 1ps

module irf_datapath
	import irf_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    ctl,
	input  logic [1:0]  in_command,
	input  logic [7:0]  in_bus_offset,
	input  logic [31:0] in_write_data,
	input  logic [7:0]  in_query_index,
	output logic [31:0] read_data,
	output logic [63:0] entry_value,
	output logic        entry_found
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [7:0] ENTRIES_B = 8'(ENTRIES);
	localparam logic [31:0] VER_VALUE = {8'h00, 8'(ENTRIES - 1), 8'h00, VER_CODE};

	// Captured request.
	cmd_t        cmd_q;
	logic [7:0]  offset_q;
	logic [31:0] wdata_q;
	logic [7:0]  qidx_q;

	logic [7:0] select_q;
	logic [3:0] apic_id_q;

	// The table is kept as two half-word memories so that a half write needs no read.
	logic [31:0] mem_lo [ENTRIES];
	logic [31:0] mem_hi [ENTRIES];
	logic [ENTRIES-1:0] vld_lo_q;
	logic [ENTRIES-1:0] vld_hi_q;

	// Execute-stage results.
	logic [31:0] rd_lo_s1;
	logic [31:0] rd_hi_s1;
	logic        rd_vlo_s1;
	logic        rd_vhi_s1;
	logic [31:0] direct_s1;
	res_kind_t   kind_s1;

	// Decode of the select register into a table slot.
	logic [7:0]       rel;
	logic             tbl_hit;
	logic             tbl_upper;
	logic [IDX_W-1:0] tbl_slot;
	logic             q_hit;
	logic [IDX_W-1:0] rd_addr;
	logic             win_wr;
	logic [31:0]      direct_d;
	res_kind_t        kind_d;
	logic [31:0]      lo_val;
	logic [31:0]      hi_val;

	always_comb begin
		rel       = select_q - SEL_TABLE;
		tbl_hit   = (select_q >= SEL_TABLE) && ({1'b0, rel[7:1]} < ENTRIES_B);
		tbl_upper = rel[0];
		tbl_slot  = tbl_hit ? IDX_W'(rel[7:1]) : '0;
		q_hit     = (qidx_q < ENTRIES_B);
		rd_addr   = (cmd_q == CMD_QUERY) ? (q_hit ? IDX_W'(qidx_q) : '0) : tbl_slot;
		win_wr    = ctl.exec && (cmd_q == CMD_WRITE) && (offset_q == OFF_WINDOW);
	end

	always_comb begin
		direct_d = '0;
		kind_d   = RES_DIRECT;
		case (cmd_q)
			CMD_READ: begin
				if (offset_q == OFF_SELECT) begin
					direct_d = {24'h0, select_q};
				end else if (offset_q == OFF_WINDOW) begin
					if (select_q == SEL_ID) begin
						direct_d = {4'h0, apic_id_q, 24'h0};
					end else if (select_q == SEL_VER) begin
						direct_d = VER_VALUE;
					end else if (select_q == SEL_ARB) begin
						direct_d = '0;
					end else if (tbl_hit) begin
						kind_d = tbl_upper ? RES_TBL_HI : RES_TBL_LO;
					end
				end
			end
			CMD_QUERY: begin
				if (q_hit) begin
					kind_d = RES_QUERY;
				end
			end
			default: begin
				direct_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd_t'(in_command);
			offset_q <= in_bus_offset;
			wdata_q  <= in_write_data;
			qidx_q   <= in_query_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q  <= '0;
			apic_id_q <= '0;
			vld_lo_q  <= '0;
			vld_hi_q  <= '0;
		end else if (ctl.exec && (cmd_q == CMD_WRITE)) begin
			if (offset_q == OFF_SELECT) begin
				select_q <= wdata_q[7:0];
			end else if (offset_q == OFF_WINDOW) begin
				if (select_q == SEL_ID) begin
					apic_id_q <= wdata_q[27:24];
				end else if (tbl_hit) begin
					if (tbl_upper) begin
						vld_hi_q[tbl_slot] <= 1'b1;
					end else begin
						vld_lo_q[tbl_slot] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_wr && tbl_hit && (select_q != SEL_ID)) begin
			if (tbl_upper) begin
				mem_hi[tbl_slot] <= wdata_q;
			end else begin
				mem_lo[tbl_slot] <= wdata_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rd_lo_s1  <= mem_lo[rd_addr];
			rd_hi_s1  <= mem_hi[rd_addr];
			rd_vlo_s1 <= vld_lo_q[rd_addr];
			rd_vhi_s1 <= vld_hi_q[rd_addr];
			direct_s1 <= direct_d;
			kind_s1   <= kind_d;
		end
	end

	// Halves never written still read as the cleared value.
	assign lo_val = rd_vlo_s1 ? rd_lo_s1 : '0;
	assign hi_val = rd_vhi_s1 ? rd_hi_s1 : '0;

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			case (kind_s1)
				RES_TBL_LO: begin
					read_data   <= lo_val;
					entry_value <= '0;
					entry_found <= 1'b0;
				end
				RES_TBL_HI: begin
					read_data   <= hi_val;
					entry_value <= '0;
					entry_found <= 1'b0;
				end
				RES_QUERY: begin
					read_data   <= '0;
					entry_value <= {hi_val, lo_val};
					entry_found <= 1'b1;
				end
				default: begin
					read_data   <= direct_s1;
					entry_value <= '0;
					entry_found <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: design/ioapic_register_file.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit up)                          tuser
// s_axis   in         bus_offset[7:0] write_data[39:8]            command[1:0]
//                     query_index[47:40]
// m_axis   out        read_data[31:0] entry_value[95:32]          entry_found
//
// Each request is captured at acceptance; the execute step then reads the table memory and
// updates the registers, and the form step loads the result into the output register once
// the output is free. One request is in work at a time and s_axis_tready is high only
// while the sequencer waits, so a new request is not accepted until the last result has
// been loaded. A waiting result holds only the result-forming step.
// Reset clears the select and ID registers and the per-half table valid bits at once.

module ioapic_register_file
	import irf_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // bus_offset, write_data, query_index
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // read_data, entry_value
	output logic        m_axis_tuser   // entry_found
);

	ctl_cmd_t ctl;

	irf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.ctl           (ctl)
	);

	irf_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.in_command     (s_axis_tuser),
		.in_bus_offset  (s_axis_tdata[7:0]),
		.in_write_data  (s_axis_tdata[39:8]),
		.in_query_index (s_axis_tdata[47:40]),
		.read_data      (m_axis_tdata[31:0]),
		.entry_value    (m_axis_tdata[95:32]),
		.entry_found    (m_axis_tuser)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import irf_pkg::*;

	localparam int NENT = DEF_ENTRIES;
	localparam int STALL_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [7:0]  qidx;
	} request_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [63:0] entry_value;
		logic        entry_found;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // bus_offset, write_data, query_index
	logic [1:0]  s_axis_tuser = '0;  // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;  // read_data, entry_value
	logic        m_axis_tuser;  // entry_found

	// Mirror of the register file contents.
	logic [7:0]  sel_mirror;
	logic [3:0]  id_mirror;
	logic [63:0] table_mirror [0:NENT-1];

	request_t pending_requests [$];
	result_t  expected_results [$];
	request_t next_request;
	request_t seen_request;
	result_t  oldest_result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_tag = 0;
	int hold_seen = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;

	ioapic_register_file #(.ENTRIES(NENT)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
		if (mismatch_count < 100)
			$display("mismatch on %s: got %h, expected %h", field, got, want);
		mismatch_count++;
	endtask

	// Applies one request to the mirror and returns the result it should produce.
	function automatic result_t apply_register_access(request_t req);
		result_t res;
		logic [7:0] rel;
		int slot;
		res = '0;
		rel = sel_mirror - SEL_TABLE;
		slot = int'(rel >> 1);
		case (req.cmd)
		CMD_READ: begin
			if (req.offset == OFF_SELECT) begin
				res.read_data = {24'h0, sel_mirror};
			end else if (req.offset == OFF_WINDOW) begin
				// Arbitration and reserved selects fall through and read as zero.
				if (sel_mirror == SEL_ID)
					res.read_data = {4'h0, id_mirror, 24'h0};
				else if (sel_mirror == SEL_VER)
					res.read_data = {8'h00, 8'(NENT - 1), 8'h00, VER_CODE};
				else if (sel_mirror >= SEL_TABLE && slot < NENT)
					res.read_data = rel[0] ? table_mirror[slot][63:32] :
						table_mirror[slot][31:0];
			end
		end
		CMD_WRITE: begin
			if (req.offset == OFF_SELECT) begin
				sel_mirror = req.wdata[7:0];
			end else if (req.offset == OFF_WINDOW) begin
				if (sel_mirror == SEL_ID)
					id_mirror = req.wdata[27:24];
				else if (sel_mirror >= SEL_TABLE && slot < NENT) begin
					if (rel[0])
						table_mirror[slot][63:32] = req.wdata;
					else
						table_mirror[slot][31:0] = req.wdata;
				end
			end
		end
		CMD_QUERY: begin
			if (req.qidx < NENT) begin
				res.entry_value = table_mirror[req.qidx];
				res.entry_found = 1'b1;
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	function automatic void push_request(cmd_t cmd, logic [7:0] offset, logic [31:0] wdata,
			logic [7:0] qidx);
		request_t req;
		req.cmd = cmd;
		req.offset = offset;
		req.wdata = wdata;
		req.qidx = qidx;
		pending_requests.push_back(req);
	endfunction

	// Mostly registers that exist, with some reserved and out-of-range selects.
	function automatic logic [7:0] pick_select();
		logic [7:0] sel;
		case ($urandom_range(0, 9))
		0: sel = SEL_ID;
		1: sel = SEL_VER;
		2: sel = SEL_ARB;
		3: sel = 8'($urandom_range(3, 15));
		8: sel = 8'($urandom_range(SEL_TABLE + 2 * NENT, 255));
		9: sel = 8'($urandom);
		default: sel = 8'(SEL_TABLE + $urandom_range(0, 2 * NENT - 1));
		endcase
		return sel;
	endfunction

	task automatic queue_random(int count);
		request_t req;
		for (int i = 0; i < count; i++) begin
			req.wdata = $urandom;
			req.qidx = 8'($urandom);
			req.offset = OFF_WINDOW;
			req.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: begin
				req.cmd = CMD_WRITE;
				req.offset = OFF_SELECT;
				req.wdata[7:0] = pick_select();
			end
			6, 7: req.offset = OFF_SELECT;
			8, 9, 10, 11, 12, 13: ;
			14, 15, 16: begin
				req.cmd = CMD_QUERY;
				if ($urandom_range(0, 4) != 0)
					req.qidx = 8'($urandom_range(0, NENT - 1));
			end
			17, 18: req.offset = 8'($urandom);
			default: begin
				req.cmd = CMD_NONE;
				req.offset = 8'($urandom);
			end
			endcase
			pending_requests.push_back(req);
		end
	endtask

	task automatic wait_for_drain();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: a request stays on the bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_request = pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {next_request.qidx, next_request.wdata, next_request.offset};
				s_axis_tuser <= next_request.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started whenever hold_tag changes.
	always @(posedge clk) begin
		if (hold_seen != hold_tag) begin
			hold_seen <= hold_tag;
			stall_left <= STALL_CYCLES;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen_request.cmd = cmd_t'(s_axis_tuser);
				seen_request.offset = s_axis_tdata[7:0];
				seen_request.wdata = s_axis_tdata[39:8];
				seen_request.qidx = s_axis_tdata[47:40];
				expected_results.push_back(apply_register_access(seen_request));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with no request pending", 64'(m_axis_tdata[31:0]), 0);
				end else begin
					oldest_result = expected_results.pop_front();
					if (m_axis_tdata[31:0] !== oldest_result.read_data)
						flag_mismatch("read_data", 64'(m_axis_tdata[31:0]),
							64'(oldest_result.read_data));
					if (m_axis_tdata[95:32] !== oldest_result.entry_value)
						flag_mismatch("entry_value", m_axis_tdata[95:32],
							oldest_result.entry_value);
					if (m_axis_tuser !== oldest_result.entry_found)
						flag_mismatch("entry_found", 64'(m_axis_tuser),
							64'(oldest_result.entry_found));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sel_mirror = '0;
		id_mirror = '0;
		for (int i = 0; i < NENT; i++)
			table_mirror[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 9;
		recv_idle_pct = 88;
		push_request(CMD_READ, OFF_SELECT, 32'hFFFFFFFF, 8'hFF);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		// Only bits 27:24 of an ID write are kept.
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, {24'hFFFFFF, SEL_VER}, 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, {24'h0, SEL_ARB}, 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, 32'h0000000F, 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, {24'h0, SEL_TABLE}, 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, 32'(SEL_TABLE + 2 * NENT - 1), 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hA5A5A5A5, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_QUERY, OFF_SELECT, 32'h0, 8'h00);
		push_request(CMD_QUERY, OFF_SELECT, 32'h0, 8'(NENT - 1));
		push_request(CMD_QUERY, OFF_SELECT, 32'h0, 8'(NENT));
		push_request(CMD_QUERY, OFF_WINDOW, 32'hFFFFFFFF, 8'hFF);
		// One past the last table half behaves like a reserved select.
		push_request(CMD_WRITE, OFF_SELECT, 32'(SEL_TABLE + 2 * NENT), 8'h00);
		push_request(CMD_WRITE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, OFF_WINDOW, 32'h0, 8'h00);
		push_request(CMD_WRITE, 8'hFF, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_READ, 8'h04, 32'h0, 8'h00);
		push_request(CMD_NONE, OFF_WINDOW, 32'hFFFFFFFF, 8'h00);
		push_request(CMD_WRITE, OFF_SELECT, 32'h000000FF, 8'h00);
		push_request(CMD_READ, OFF_SELECT, 32'h0, 8'h00);
		queue_random(620);
		wait_for_drain();

		send_idle_pct = 88;
		recv_idle_pct = 9;
		queue_random(620);
		wait_for_drain();

		// No idling; the receiver holds off once so the request side backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(640);
		hold_tag = hold_tag + 1;
		wait_for_drain();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			flag_mismatch("results never delivered", 64'(expected_results.size()), 0);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
